### sv/frame_bitmap_allocator_defines.svh
// Assertion helpers; each expects clk and rst_n in the enclosing module.
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fba_pkg.sv
package fba_pkg;

  localparam int NUM_FRAMES_DEF = 4096;
  localparam int WORD_BITS      = 64;
  localparam int FRAME_SHIFT    = 12;
  localparam int ADDR_W         = 24;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 13;
  localparam int FRAME_NUM_W    = ADDR_W - FRAME_SHIFT;

  localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic scan;
    logic free_op;
    logic resp_load;
  } fba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic last_word;
    logic out_free;
  } fba_sts_t;

endpackage

### sv/fba_ram.sv
module fba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/fba_ctrl.sv
module fba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_stall,
  output fba_pkg::fba_cmd_t cmd,
  input  fba_pkg::fba_sts_t sts
);
  import fba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = (in_req_type == REQ_FREE) ? S_FREE : S_SCAN;
      end
      S_SCAN: begin
        if (sts.found || sts.last_word) state_nxt = S_RESP;
      end
      S_FREE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLR:  cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_FREE: cmd.free_op = 1'b1;
      S_RESP: cmd.resp_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### sv/fba_dp.sv
module fba_dp #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fba_pkg::fba_cmd_t             cmd,
  output fba_pkg::fba_sts_t             sts,
  input  logic                          in_req_type,
  input  logic [fba_pkg::ADDR_W-1:0]    in_free_addr,
  input  logic                          cfg_wr_en,
  input  logic [fba_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [fba_pkg::ADDR_W-1:0]    out_alloc_addr,
  output logic [fba_pkg::STATUS_W-1:0]  out_status
);
  import fba_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int NW        = $clog2(NUM_FRAMES + 1);
  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

  logic [COUNT_W-1:0]     count_r;
  logic [WW-1:0]          idx_r;
  logic [FRAME_NUM_W-1:0] frame_r;
  logic [ADDR_W-1:0]      res_addr_r;
  logic [STATUS_W-1:0]    res_status_r;
  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [STATUS_W-1:0]    out_status_r;

  logic [NW-1:0]          limit;
  logic [WORD_BITS-1:0]   rd_data;
  logic [WORD_BITS-1:0]   avail_mask;
  logic [WORD_BITS-1:0]   free_bits;
  logic [5:0]             bit_pos;
  logic                   found;
  logic                   last_word;
  logic                   beyond;
  logic [WW-1:0]          in_word;
  logic [WW-1:0]          rd_addr;
  logic                   wr_en;
  logic [WORD_BITS-1:0]   wr_data;
  logic [31:0]            limit_words;
  logic [31:0]            addr_full;
  logic [FRAME_NUM_W-1:0] in_frame;

  fba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // effective frame count saturates at the map size
  always_comb begin
    if (32'(count_r) > 32'(NUM_FRAMES)) limit = NW'(NUM_FRAMES);
    else                                limit = NW'(count_r);
  end

  assign in_frame    = in_free_addr[ADDR_W-1:FRAME_SHIFT];
  assign in_word     = WW'(32'(in_frame) >> 6);
  assign limit_words = 32'(limit) >> 6;
  assign last_word   = (idx_r == LAST_WORD);
  assign beyond      = 32'(frame_r) >= 32'(limit);

  // frames of the current word that lie below the count
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if (limit_words > 32'(idx_r))       avail_mask[i] = 1'b1;
      else if (limit_words == 32'(idx_r)) avail_mask[i] = (6'(i) < limit[5:0]);
      else                                avail_mask[i] = 1'b0;
    end
  end

  assign free_bits = ~rd_data & avail_mask;
  assign found     = |free_bits;

  always_comb begin
    bit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) bit_pos = 6'(i);
    end
  end

  assign addr_full = (32'(idx_r) << 18) | (32'(bit_pos) << FRAME_SHIFT);

  // prefetch the next word during a scan, else the word of the free address (word 0 for an allocate)
  always_comb begin
    if (cmd.scan) begin
      rd_addr = last_word ? idx_r : idx_r + WW'(1);
    end else begin
      rd_addr = (in_req_type == REQ_FREE) ? in_word : '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '1;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.scan && found) begin
      wr_en   = 1'b1;
      wr_data = rd_data | (WORD_BITS'(1) << bit_pos);
    end else if (cmd.free_op && !beyond) begin
      wr_en   = 1'b1;
      wr_data = rd_data & ~(WORD_BITS'(1) << frame_r[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RST;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) count_r <= cfg_wr_data;
      if (cmd.clr_wr) begin
        idx_r <= last_word ? '0 : idx_r + WW'(1);
      end else if (cmd.load) begin
        idx_r <= (in_req_type == REQ_FREE) ? in_word : '0;
      end else if (cmd.scan && !found && !last_word) begin
        idx_r <= idx_r + WW'(1);
      end
      if (cmd.resp_load)   out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) frame_r <= in_frame;
    if (cmd.scan) begin
      res_addr_r   <= found ? addr_full[ADDR_W-1:0] : '0;
      res_status_r <= found ? ST_OK : ST_NO_FRAME;
    end else if (cmd.free_op) begin
      res_addr_r   <= '0;
      res_status_r <= beyond ? ST_BEYOND : ST_OK;
    end
    if (cmd.resp_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.clr_last  = last_word;
  assign sts.found     = found;
  assign sts.last_word = last_word;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;

endmodule

### sv/frame_bitmap_allocator.sv
// Channel   Ports                                   Direction
// input     in_valid, in_stall, in_req_type,        request in
//           in_free_addr
// result    out_valid, out_stall, out_alloc_addr,   one result per request
//           out_status
// config    cfg_wr_en, cfg_wr_data                  frame count write
//
// Allocate: the scan reads 1 to NUM_FRAMES/64 words (rounded up) and stops at the first
// word with a free frame below the count; the map RAM returns one 64-bit word per cycle.
// Free: one read-modify-write of the map RAM, with no write for a frame beyond the count.
// After reset the map is filled with ones, one word per cycle over all
// NUM_FRAMES/64 words (rounded up), with in_stall high throughout.
// One request at a time; a finished result waits in the output register
// while the next request is taken.
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [fba_pkg::ADDR_W-1:0]    in_free_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fba_pkg::ADDR_W-1:0]    out_alloc_addr,
  output logic [fba_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_wr_en,
  input  logic [fba_pkg::COUNT_W-1:0]   cfg_wr_data
);
  import fba_pkg::*;

  fba_cmd_t cmd;
  fba_sts_t sts;

  fba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  fba_dp #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_free_addr   (in_free_addr),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_alloc_addr (out_alloc_addr),
    .out_status     (out_status)
  );

  `FBA_ASSERT_NOW(a_no_accept_in_clear, cmd.clr_wr, in_stall, "transfer during map clear")
  `FBA_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second request taken")
  `FBA_ASSERT_NOW(a_no_frame_addr_zero, out_valid && out_status == ST_NO_FRAME,
    out_alloc_addr == '0, "no-frame result with nonzero address")
  `FBA_ASSERT_NOW(a_status_code, out_valid,
    out_status == ST_OK || out_status == ST_NO_FRAME || out_status == ST_BEYOND,
    "undefined status code")

endmodule
